// ----- rtl/core/lzwenc_pkg.sv -----
package lzwenc_pkg;

  localparam int DEF_DICT_DEPTH  = 4096;
  localparam int DEF_SYMBOL_BITS = 8;

  localparam int SYM_W      = 8;   // symbol field on the input channel
  localparam int ALPHA_W    = 9;   // alphabet size register
  localparam int CODE_OUT_W = 12;  // code field on the output channel
  localparam int CW_OUT_W   = 4;   // code width field on the output channel

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch an input transaction
    logic open;        // start a stream with the held symbol
    logic rd_head;     // read the first child of the current prefix
    logic probe_head;  // read the node named by the first child
    logic probe_next;  // read the node named by the sibling link
    logic clear_head;  // first child turned out stale
    logic take_hit;    // extend the prefix to the matched node
    logic emit_miss;   // emit prefix, add the new entry if the dictionary has room
    logic emit_flush;  // emit the final prefix and close the stream
  } cmd_t;

  typedef struct packed {
    logic in_alpha;     // held symbol is inside the alphabet
    logic pv;           // a prefix is held
    logic fin;          // held symbol closes the stream
    logic fc_in_range;  // first child read data names a live entry
    logic match_prefix; // probed node hangs under the current prefix
    logic match_sym;    // probed node carries the held symbol
    logic ns_in_range;  // sibling link of probed node names a live entry
    logic out_free;     // output register can take a result
    logic clearing;     // first-child links still being cleared after reset
  } status_t;

  // ceil(log2(n)) for an alphabet-sized value
  function automatic logic [3:0] clog2_alpha(input logic [ALPHA_W-1:0] n);
    logic [3:0] w;
    w = '0;
    for (int i = 0; i < ALPHA_W; i++) begin
      if (n > (ALPHA_W'(1) << i)) w = 4'(i + 1);
    end
    return w;
  endfunction

endpackage

// ----- rtl/core/lzwenc_ctrl.sv -----
module lzwenc_ctrl
  import lzwenc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HEAD,
    ST_PROBE,
    ST_MISS,
    ST_FINAL
  } state_t;

  state_t state;
  state_t state_next;
  logic   first;
  logic   first_next;

  // take input only in idle and once the first-child clear pass is done
  assign s_tready = (state == ST_IDLE) && !status.clearing;

  always_comb begin
    cmd        = '0;
    state_next = state;
    first_next = first;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && !status.clearing) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.in_alpha) begin
          state_next = ST_FINAL;
        end else if (!status.pv) begin
          cmd.open   = 1'b1;
          state_next = ST_FINAL;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = ST_HEAD;
        end
      end
      ST_HEAD: begin
        // always probe so the datapath records whether the head is live
        cmd.probe_head = 1'b1;
        first_next     = 1'b1;
        state_next     = status.fc_in_range ? ST_PROBE : ST_MISS;
      end
      ST_PROBE: begin
        if (status.match_prefix && status.match_sym) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_FINAL;
        end else if (status.match_prefix && status.ns_in_range) begin
          cmd.probe_next = 1'b1;
          first_next     = 1'b0;
          state_next     = ST_PROBE;
        end else begin
          cmd.clear_head = first && !status.match_prefix;
          state_next     = ST_MISS;
        end
      end
      ST_MISS: begin
        if (status.out_free) begin
          cmd.emit_miss = 1'b1;
          state_next    = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (status.fin && status.pv) begin
          if (status.out_free) begin
            cmd.emit_flush = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_miss || cmd.emit_flush) |-> status.out_free)
    else $error("result emitted into a full output register");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_CHECK))
    else $error("captured transaction did not start a lookup");

  a_probe_follows_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ($past(state) == ST_HEAD || $past(state) == ST_PROBE))
    else $error("probe entered without a head read");

endmodule

// ----- rtl/core/lzwenc_dp.sv -----
module lzwenc_dp
  import lzwenc_pkg::*;
#(
  parameter int DICT_DEPTH  = DEF_DICT_DEPTH,
  parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [SYM_W-1:0]                 s_tdata,
  input  logic                             s_tlast,
  input  logic                             cfg_wr_en,
  input  logic [ALPHA_W-1:0]               cfg_wr_data,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [CW_OUT_W+CODE_OUT_W-1:0]   m_tdata,
  output logic                             m_tlast,
  input  cmd_t                             cmd,
  output status_t                          status
);

  localparam int CODE_W    = $clog2(DICT_DEPTH);
  localparam int NFC_W     = $clog2(DICT_DEPTH + 1);
  localparam int CW_W      = $clog2(CODE_W + 1);
  localparam int ALPHA_LIM = ((1 << SYMBOL_BITS) < DICT_DEPTH) ? (1 << SYMBOL_BITS)
                                                              : DICT_DEPTH;
  localparam int CMP_W     = (NFC_W > ALPHA_W) ? NFC_W : ALPHA_W;

  // trie kept per code: parent, symbol, first child, next sibling
  logic [CODE_W-1:0]      ep_mem [DICT_DEPTH];
  logic [SYMBOL_BITS-1:0] es_mem [DICT_DEPTH];
  logic [CODE_W-1:0]      fc_mem [DICT_DEPTH];
  logic [CODE_W-1:0]      ns_mem [DICT_DEPTH];

  logic [ALPHA_W-1:0]     cfg_alpha;
  logic [ALPHA_W-1:0]     active;
  logic [NFC_W-1:0]       nfc;
  logic [CW_W-1:0]        cw;
  logic [CODE_W-1:0]      prefix;
  logic                   pv;
  logic [SYM_W-1:0]       sym;
  logic                   fin;
  logic [CODE_W-1:0]      cand;
  logic [CODE_W-1:0]      head;
  logic                   head_ok;
  logic [CODE_W-1:0]      fc_rd;
  logic [CODE_W-1:0]      ep_rd;
  logic [SYMBOL_BITS-1:0] es_rd;
  logic [CODE_W-1:0]      ns_rd;
  logic [CODE_W-1:0]      clr_addr;
  logic                   clearing;

  logic [ALPHA_W-1:0]     alpha_clamp;
  logic [ALPHA_W-1:0]     alpha_eff;
  logic                   room;
  logic [CODE_W-1:0]      waddr;
  logic [CODE_W-1:0]      node_addr;
  logic                   out_free;

  always_comb begin
    if (cfg_alpha == '0) begin
      alpha_clamp = ALPHA_W'(1);
    end else if (cfg_alpha > ALPHA_W'(ALPHA_LIM)) begin
      alpha_clamp = ALPHA_W'(ALPHA_LIM);
    end else begin
      alpha_clamp = cfg_alpha;
    end
  end

  assign alpha_eff = pv ? active : alpha_clamp;
  assign room      = nfc < NFC_W'(DICT_DEPTH);
  assign waddr     = nfc[CODE_W-1:0];
  assign node_addr = cmd.probe_head ? fc_rd : ns_rd;
  assign out_free  = !m_tvalid || m_tready;

  // a code is live when it was allocated in the open stream
  assign status.fc_in_range = (CMP_W'(fc_rd) >= CMP_W'(active)) &&
                              (CMP_W'(fc_rd) < CMP_W'(nfc));
  assign status.ns_in_range = (CMP_W'(ns_rd) >= CMP_W'(active)) &&
                              (CMP_W'(ns_rd) < CMP_W'(nfc));
  assign status.in_alpha     = ALPHA_W'(sym) < alpha_eff;
  assign status.pv           = pv;
  assign status.fin          = fin;
  assign status.match_prefix = (ep_rd == prefix);
  assign status.match_sym    = (es_rd == SYMBOL_BITS'(sym));
  assign status.out_free     = out_free;
  assign status.clearing     = clearing;

  always_ff @(posedge clk) begin
    if (cmd.emit_miss && room) begin
      ep_mem[waddr]  <= prefix;
      es_mem[waddr]  <= SYMBOL_BITS'(sym);
      ns_mem[waddr]  <= head_ok ? head : '0;
    end
    // code zero is never live, so it marks a code with no children
    if (clearing) begin
      fc_mem[clr_addr] <= '0;
    end else if (cmd.emit_miss && room) begin
      fc_mem[prefix] <= waddr;
    end
    if (cmd.rd_head) begin
      fc_rd <= fc_mem[prefix];
    end
    if (cmd.probe_head || cmd.probe_next) begin
      ep_rd <= ep_mem[node_addr];
      es_rd <= es_mem[node_addr];
      ns_rd <= ns_mem[node_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_alpha <= ALPHA_RESET;
      active    <= ALPHA_RESET;
      nfc       <= NFC_W'(ALPHA_RESET);
      cw        <= CW_W'(1);
      prefix    <= '0;
      pv        <= 1'b0;
      head_ok   <= 1'b0;
      m_tvalid  <= 1'b0;
      clr_addr  <= '0;
      clearing  <= 1'b1;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + CODE_W'(1);
        if (clr_addr == CODE_W'(DICT_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_wr_en) begin
        cfg_alpha <= cfg_wr_data;
      end
      if (cmd.open) begin
        active <= alpha_eff;
        nfc    <= NFC_W'(alpha_eff);
        cw     <= CW_W'(clog2_alpha(alpha_eff));
        prefix <= CODE_W'(sym);
        pv     <= 1'b1;
      end
      if (cmd.probe_head) begin
        head_ok <= status.fc_in_range;
      end else if (cmd.clear_head) begin
        head_ok <= 1'b0;
      end
      if (cmd.take_hit) begin
        prefix <= cand;
      end
      if (cmd.emit_miss) begin
        prefix <= CODE_W'(sym);
        if (room) begin
          nfc <= nfc + NFC_W'(1);
          // width grows once the size passes the next power of two
          if ((NFC_W + 1)'(nfc) == ((NFC_W + 1)'(1) << cw)) begin
            cw <= cw + CW_W'(1);
          end
        end
      end
      if (cmd.emit_flush) begin
        pv     <= 1'b0;
        prefix <= '0;
      end
      if (cmd.emit_miss || cmd.emit_flush) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym <= s_tdata;
      fin <= s_tlast;
    end
    if (cmd.probe_head) begin
      cand <= fc_rd;
      head <= fc_rd;
    end else if (cmd.probe_next) begin
      cand <= ns_rd;
    end
    if (cmd.emit_miss || cmd.emit_flush) begin
      m_tdata <= {CW_OUT_W'(cw), CODE_OUT_W'(prefix)};
      m_tlast <= cmd.emit_flush;
    end
  end

  a_width_covers_size: assert property (@(posedge clk) disable iff (rst)
    pv |-> ((NFC_W + 1)'(nfc) <= ((NFC_W + 1)'(1) << cw)))
    else $error("code width too narrow for dictionary size");

  a_nfc_bounded: assert property (@(posedge clk) disable iff (rst)
    nfc <= NFC_W'(DICT_DEPTH))
    else $error("next free code past dictionary end");

  a_flush_closes: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_flush |=> (!pv && m_tvalid && m_tlast))
    else $error("flush did not close the stream");

endmodule

// ----- rtl/core/lzw_encoder_variable_width_top.sv -----
// LZW encoder with variable code width over a programmable alphabet.
// Input channel (s_*): one symbol index per transaction in s_tdata[7:0];
// s_tlast marks the last symbol of a stream and forces a flush.
// Output channel (m_*): one code per transaction, m_tdata[11:0] the code,
// m_tdata[15:12] its width in bits; m_tlast marks the flushed final code.
// cfg_wr_en/cfg_wr_data load the alphabet size; it is latched when the next
// stream opens, so write it between streams.
// Each symbol is captured and checked; one that opens a stream or is out
// of the alphabet needs no lookup. Otherwise the prefix's first child is
// read and trie nodes are probed, one per cycle, until a hit or a miss (at
// most the number of children of the current prefix, so up to the alphabet
// size). A flush goes out from the closing state, waiting only while the
// output register holds an untaken code. The dictionary is a trie in
// single-port memories (first child, sibling link, parent, symbol).
// A stream may produce two codes from one symbol (a miss plus the flush).
// The output register holds one result and decouples the two sides: a
// stalled receiver stalls the block only when a new code must be emitted.
// Reset (rst, synchronous) closes any stream, sets the alphabet size to 2 and
// clears all DICT_DEPTH first-child links with s_tready low; stale
// entries elsewhere are rejected by range and parent checks.
module lzw_encoder_variable_width_top
  import lzwenc_pkg::*;
#(
  parameter int DICT_DEPTH  = DEF_DICT_DEPTH,
  parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [SYM_W-1:0]               s_tdata,    // [7:0] symbol
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [CW_OUT_W+CODE_OUT_W-1:0] m_tdata,    // [11:0] code, [15:12] code_width
  output logic                           m_tlast,
  input  logic                           cfg_wr_en,
  input  logic [ALPHA_W-1:0]             cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  lzwenc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lzwenc_dp #(
    .DICT_DEPTH  (DICT_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ----- tb/lzw_code_checker.sv -----
module lzw_code_checker
  import lzwenc_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [SYM_W-1:0]               s_tdata,    // [7:0] symbol
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [CW_OUT_W+CODE_OUT_W-1:0] m_tdata,    // [11:0] code, [15:12] code_width
  input  logic                           m_tlast,
  input  logic                           cfg_wr_en,
  input  logic [ALPHA_W-1:0]             cfg_wr_data,
  output int                             pending,
  output int                             errors,
  output int                             checked
);

  localparam int DEPTH     = DEF_DICT_DEPTH;
  localparam int SYM_LIMIT = ((1 << DEF_SYMBOL_BITS) < DEPTH) ? (1 << DEF_SYMBOL_BITS) : DEPTH;

  typedef struct packed {
    logic [CODE_OUT_W-1:0] code;
    logic [CW_OUT_W-1:0]   width;
    logic                  eos;
  } lzw_code_t;

  lzw_code_t            expected_codes[$];
  // pair entries of the open stream, keyed by {prefix code, symbol}
  int unsigned          pair_code[logic [CODE_OUT_W+SYM_W-1:0]];
  logic [ALPHA_W-1:0]   alpha_reg;
  int unsigned          stream_alpha;
  int unsigned          next_code;
  int unsigned          prefix;
  bit                   holding;
  int                   fail_count  = 0;
  int                   match_count = 0;

  function automatic int unsigned bits_for(int unsigned n);
    int unsigned w;
    w = 0;
    while (w < 31 && (32'd1 << w) < n) w++;
    return w;
  endfunction

  function automatic int unsigned clamp_alpha(logic [ALPHA_W-1:0] a);
    if (a == '0) return 1;
    if (a > SYM_LIMIT) return SYM_LIMIT;
    return a;
  endfunction

  function automatic lzw_code_t make_code(int unsigned c, int unsigned size, logic eos);
    lzw_code_t r;
    r.code  = CODE_OUT_W'(c);
    r.width = CW_OUT_W'(bits_for(size));
    r.eos   = eos;
    return r;
  endfunction

  task automatic flag(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  task automatic enqueue_code(lzw_code_t c);
    expected_codes.insert(expected_codes.size(), c);
  endtask

  task automatic predict_symbol(logic [SYM_W-1:0] sym, logic fin);
    int unsigned                   alpha;
    logic [CODE_OUT_W+SYM_W-1:0]   key;
    alpha = holding ? stream_alpha : clamp_alpha(alpha_reg);
    if (sym < alpha) begin
      if (!holding) begin
        // open a stream: latch the alphabet and forget the last dictionary
        stream_alpha = alpha;
        next_code    = alpha;
        prefix       = sym;
        holding      = 1'b1;
        pair_code.delete();
      end else begin
        key = {CODE_OUT_W'(prefix), sym};
        if (pair_code.exists(key)) begin
          prefix = pair_code[key];
        end else begin
          enqueue_code(make_code(prefix, next_code, 1'b0));
          if (next_code < DEPTH) begin
            pair_code[key] = next_code;
            next_code++;
          end
          prefix = sym;
        end
      end
    end
    if (fin && holding) begin
      enqueue_code(make_code(prefix, next_code, 1'b1));
      holding = 1'b0;
      prefix  = 0;
    end
  endtask

  task automatic check_code(lzw_code_t got);
    lzw_code_t want;
    if (expected_codes.size() == 0) begin
      flag($sformatf("unexpected code %0d width %0d last %0b", got.code, got.width, got.eos));
      return;
    end
    want = expected_codes.pop_front();
    if (got.code !== want.code || got.width !== want.width || got.eos !== want.eos) begin
      flag($sformatf("code mismatch: expected code %0d width %0d last %0b, got %0d %0d %0b",
                     want.code, want.width, want.eos, got.code, got.width, got.eos));
    end else begin
      match_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      alpha_reg    = ALPHA_RESET;
      holding      = 1'b0;
      prefix       = 0;
      next_code    = clamp_alpha(ALPHA_RESET);
      stream_alpha = next_code;
      expected_codes.delete();
      pair_code.delete();
    end else begin
      // retire first so an early code cannot match a same-edge prediction
      if (m_tvalid && m_tready)
        check_code({m_tdata[CODE_OUT_W-1:0], m_tdata[CW_OUT_W+CODE_OUT_W-1:CODE_OUT_W], m_tlast});
      if (s_tvalid && s_tready) predict_symbol(s_tdata, s_tlast);
      if (cfg_wr_en) alpha_reg = cfg_wr_data;
    end
    pending <= expected_codes.size();
    errors  <= fail_count;
    checked <= match_count;
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import lzwenc_pkg::*;

  localparam int SETTLE       = 300;
  localparam int LIMIT        = 2_000_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int FILL_ITEMS   = 450;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           s_tvalid    = 1'b0;
  logic                           s_tready;
  logic [SYM_W-1:0]               s_tdata     = '0;
  logic                           s_tlast     = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready    = 1'b0;
  logic [CW_OUT_W+CODE_OUT_W-1:0] m_tdata;
  logic                           m_tlast;
  logic                           cfg_wr_en   = 1'b0;
  logic [ALPHA_W-1:0]             cfg_wr_data = '0;

  int          pending;
  int          errors;
  int          checked;
  bit          calm      = 1'b0;
  int unsigned cycles    = 0;
  int unsigned sent      = 0;
  int unsigned streams   = 0;
  int unsigned settings  = 0;
  int unsigned cur_alpha = 2;

  lzw_encoder_variable_width_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lzw_code_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .errors      (errors),
    .checked     (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : (calm || $urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_symbol(logic [SYM_W-1:0] sym, logic lst);
    while (!calm && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= lst;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    sent++;
    if (lst) streams++;
  endtask

  task automatic send_run(logic [SYM_W-1:0] syms[$]);
    foreach (syms[i]) send_symbol(syms[i], i == syms.size() - 1);
  endtask

  // hold the sender until every code is out and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_alphabet(logic [ALPHA_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_alpha = (v == '0) ? 1 : (v > 256) ? 256 : v;
    settings++;
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    if (cur_alpha < 256 && $urandom_range(0, 99) < 8)
      return SYM_W'($urandom_range(255, cur_alpha));
    // lean on a few symbols so strings repeat and the trie gets hits
    if ($urandom_range(0, 99) < 50)
      return SYM_W'($urandom_range(0, ((cur_alpha < 4) ? cur_alpha : 4) - 1));
    return SYM_W'($urandom_range(0, cur_alpha - 1));
  endfunction

  task automatic run_stream(int len);
    for (int i = 0; i < len; i++) send_symbol(pick_symbol(), i == len - 1);
  endtask

  initial begin
    logic [ALPHA_W-1:0] alpha_set[$];
    int unsigned        phase;
    int unsigned        base;
    int unsigned        target;

    alpha_set = '{9'd3, 9'd1, 9'd256, 9'd16, 9'd0, 9'd5, 9'd255, 9'd2, 9'd511, 9'd64, 9'd7};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset alphabet of two: final with nothing held, lone flush, hits, drops
    send_symbol(8'd255, 1'b1);
    send_symbol(8'd0, 1'b1);
    send_run('{8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd1});
    send_run('{8'd1, 8'd7, 8'd200});
    set_alphabet(9'd1);
    send_run('{8'd0, 8'd0, 8'd0, 8'd0});
    set_alphabet(9'd256);
    send_run('{8'd255, 8'd255, 8'd255});
    // a write inside an open stream only counts from the next stream
    send_symbol(8'd10, 1'b0);
    send_symbol(8'd20, 1'b0);
    set_alphabet(9'd4);
    send_run('{8'd200, 8'd30});
    send_run('{8'd3, 8'd3, 8'd3});
    set_alphabet(9'd0);
    send_run('{8'd0, 8'd1, 8'd0});
    set_alphabet(9'd511);
    send_run('{8'd200, 8'd255});

    phase = 0;
    base  = sent;
    while (sent - base < RANDOM_ITEMS) begin
      set_alphabet(phase < alpha_set.size() ? alpha_set[phase] : ALPHA_W'($urandom_range(1, 256)));
      calm   = (phase == 2);
      target = sent + 150;
      while (sent < target) begin
        if (cur_alpha < 256 && $urandom_range(0, 99) < 5)
          send_symbol(SYM_W'($urandom_range(255, cur_alpha)), 1'b1);
        run_stream(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30));
      end
      phase++;
    end
    calm = 1'b0;

    // one long stream over the full alphabet to grow the dictionary and widen the codes
    set_alphabet(9'd256);
    for (int i = 0; i < FILL_ITEMS; i++)
      send_symbol(SYM_W'($urandom_range(0, 255)), i == FILL_ITEMS - 1);
    settle();

    $display("tb_top: %0d symbols in %0d streams under %0d alphabet writes, %0d codes matched",
             sent, streams, settings, checked);
    $display("tb_top: includes a %0d-symbol stream over the full alphabet", FILL_ITEMS);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lzwenc_pkg.sv
rtl/core/lzwenc_ctrl.sv
rtl/core/lzwenc_dp.sv
rtl/core/lzw_encoder_variable_width_top.sv
tb/lzw_code_checker.sv
tb/tb_top.sv
